[design/swsr_pkg.sv]
// Package for the single-wire sensor reader.
// Holds the result record, configuration register indexes and reset values.
// No dependencies.
`default_nettype none

package swsr_pkg;

  // Bits in one received byte, shifted in most significant bit first.
  localparam int BITS_PER_BYTE = 8;
  localparam int BIT_IDX_W     = $clog2(BITS_PER_BYTE);
  localparam int MAX_BYTES     = 8;
  localparam int BYTE_IDX_W    = $clog2(MAX_BYTES);

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int TICK_CNT_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW_TICKS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_TICKS      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_DELAY_TICKS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTES_TO_READ      = 3'd4;

  // Configuration register reset values.
  localparam logic [15:0] RESET_LOW_TICKS_RST    = 16'd20000;
  localparam logic [7:0]  RELEASE_TICKS_RST      = 8'd30;
  localparam logic [7:0]  TIMEOUT_TICKS_RST      = 8'd100;
  localparam logic [7:0]  SAMPLE_DELAY_TICKS_RST = 8'd40;
  localparam logic [3:0]  BYTES_TO_READ_RST      = 4'd5;

  // One result, produced for every accepted tick.
  typedef struct packed {
    logic       drive_low;
    logic       byte_valid;
    logic [7:0] byte_value;
    logic       last_byte;
    logic       no_response;
    logic       busy_res;
  } result_t;

endpackage

`default_nettype wire

[design/swsr_tick_if.sv]
// Input channel of the single-wire sensor reader: one request per tick.
// Carries the sampled line level and the start request. No dependencies.
`default_nettype none

interface swsr_tick_if;
  logic valid;
  logic ready;
  logic line_level;
  logic start_req;

  modport source (output valid, output line_level, output start_req, input ready);
  modport sink   (input valid, input line_level, input start_req, output ready);
endinterface

`default_nettype wire

[design/swsr_result_if.sv]
// Output channel of the single-wire sensor reader: one result per tick.
// No dependencies.
`default_nettype none

interface swsr_result_if;
  logic       valid;
  logic       ready;
  logic       drive_low;
  logic       byte_valid;
  logic [7:0] byte_value;
  logic       last_byte;
  logic       no_response;
  logic       busy_res;

  modport source (output valid, output drive_low, output byte_valid, output byte_value,
                  output last_byte, output no_response, output busy_res, input ready);
  modport sink   (input valid, input drive_low, input byte_valid, input byte_value,
                  input last_byte, input no_response, input busy_res, output ready);
endinterface

`default_nettype wire

[design/swsr_skid.sv]
// Two-entry output stage: a result register plus a spare register.
// Depends on swsr_pkg for the result record.
`default_nettype none

module swsr_skid (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire swsr_pkg::result_t push_data,
  output logic                  pop_valid,
  input  wire logic             pop_ready,
  output swsr_pkg::result_t     pop_data
);
  import swsr_pkg::*;

  logic    main_valid;
  result_t main_data;
  logic    spare_valid;
  result_t spare_data;
  logic    push;
  logic    pop;

  assign push_ready = !spare_valid;
  assign push       = push_valid && push_ready;
  assign pop        = main_valid && pop_ready;
  assign pop_valid  = main_valid;
  assign pop_data   = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid  <= 1'b0;
      spare_valid <= 1'b0;
    end else if (!main_valid || pop) begin
      // The spare entry is older than anything on the push side, and a full
      // spare blocks pushes, so it always moves first.
      if (spare_valid) begin
        main_valid  <= 1'b1;
        spare_valid <= 1'b0;
      end else begin
        main_valid <= push;
      end
    end else if (push) begin
      spare_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_valid || pop) begin
      if (spare_valid) begin
        main_data <= spare_data;
      end else begin
        main_data <= push_data;
      end
    end else if (push) begin
      spare_data <= push_data;
    end
  end

endmodule

`default_nettype wire

[design/single_wire_sensor_reader.sv]
// Top level of the single-wire sensor reader (host side of a DHT11-style link).
// Depends on swsr_pkg, swsr_tick_if, swsr_result_if and swsr_skid.
//
// Each request on tick_in stands for one microsecond of line time and carries
// the sampled data line and a start request; each request yields exactly one
// result on result_out. A start in idle drives the line low for
// reset_low_ticks ticks, releases it for release_ticks ticks, then checks the
// sensor's response: the line must go low and then high, each within
// timeout_ticks ticks, or no_response is raised for one tick and the block
// returns to idle. Each data bit waits for a low level and then a high level
// (a timeout only ends the wait), lets sample_delay_ticks ticks pass, and then
// samples the line. Bits are gathered most significant first; a full byte is
// presented with byte_valid for one tick, and last_byte marks the final one
// of bytes_to_read (0 is taken as 1, values above 8 as 8). Throughput is one
// tick per clock cycle: the phase sequencer updates in the same cycle that it
// takes a request, and the result goes into a result register with one spare
// entry behind it. A request is taken every cycle while the consumer takes
// every result; a result held back stalls the input, since the spare entry
// must drain before the next request is taken. With nothing queued, a result
// appears in the cycle after its request. Configuration is written through
// cfg_write, cfg_index and cfg_data; the user must do so only while the block
// is idle, which the block does not enforce. Unused indexes are ignored.
`default_nettype none

module single_wire_sensor_reader (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_write,
  input  wire logic [swsr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [swsr_pkg::CFG_DATA_W-1:0] cfg_data,
  swsr_tick_if.sink                           tick_in,
  swsr_result_if.source                       result_out
);
  import swsr_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LOW,
    PH_RELEASE,
    PH_RESP_LOW,
    PH_RESP_HIGH,
    PH_BIT_LOW,
    PH_BIT_HIGH,
    PH_DELAY
  } phase_t;

  // Configuration registers.
  logic [15:0] reset_low_ticks;
  logic [7:0]  release_ticks;
  logic [7:0]  timeout_ticks;
  logic [7:0]  sample_delay_ticks;
  logic [3:0]  bytes_to_read;

  // Sequencer state.
  phase_t                  phase;
  phase_t                  phase_next;
  logic [TICK_CNT_W-1:0]   tick_count;
  logic [TICK_CNT_W-1:0]   tick_count_next;
  logic [BIT_IDX_W-1:0]    bit_index;
  logic [BIT_IDX_W-1:0]    bit_index_next;
  logic [BYTE_IDX_W-1:0]   byte_index;
  logic [BYTE_IDX_W-1:0]   byte_index_next;
  logic [BITS_PER_BYTE-1:0] shift_byte;
  logic [BITS_PER_BYTE-1:0] shift_byte_next;

  // State as seen by this tick, after a start in idle has taken effect.
  logic                     start_now;
  phase_t                   phase_cur;
  logic [TICK_CNT_W-1:0]    count_cur;
  logic [BIT_IDX_W-1:0]     bit_cur;
  logic [BYTE_IDX_W-1:0]    byte_cur;
  logic [BITS_PER_BYTE-1:0] shift_cur;
  logic [TICK_CNT_W-1:0]    count_inc;
  logic [TICK_CNT_W-1:0]    timeout_limit;
  logic [TICK_CNT_W-1:0]    release_limit;
  logic [TICK_CNT_W-1:0]    delay_limit;
  logic [3:0]               want_bytes;
  logic [3:0]               bytes_done;
  logic [BITS_PER_BYTE-1:0] sampled_byte;

  result_t result;
  logic    tick_accept;
  logic    skid_ready;
  result_t out_data;

  assign tick_accept   = tick_in.valid && skid_ready;
  assign tick_in.ready = skid_ready;

  assign start_now = (phase == PH_IDLE) && tick_in.start_req;
  assign phase_cur = start_now ? PH_LOW : phase;
  assign count_cur = start_now ? '0 : tick_count;
  assign bit_cur   = start_now ? '0 : bit_index;
  assign byte_cur  = start_now ? '0 : byte_index;
  assign shift_cur = start_now ? '0 : shift_byte;
  assign count_inc = count_cur + TICK_CNT_W'(1);

  assign timeout_limit = {8'd0, timeout_ticks};
  assign release_limit = {8'd0, release_ticks};
  assign delay_limit   = {8'd0, sample_delay_ticks};

  // Requested byte count, clamped to the range one through eight.
  always_comb begin
    if (bytes_to_read == 4'd0) begin
      want_bytes = 4'd1;
    end else if (bytes_to_read > 4'(MAX_BYTES)) begin
      want_bytes = 4'(MAX_BYTES);
    end else begin
      want_bytes = bytes_to_read;
    end
  end

  assign bytes_done   = {1'b0, byte_cur} + 4'd1;
  assign sampled_byte = {shift_cur[BITS_PER_BYTE-2:0], tick_in.line_level};

  // One tick of the phase sequencer. Leaving a timed phase clears the counter.
  always_comb begin
    phase_next      = phase_cur;
    tick_count_next = count_cur;
    bit_index_next  = bit_cur;
    byte_index_next = byte_cur;
    shift_byte_next = shift_cur;
    result          = '0;
    result.busy_res = (phase_cur != PH_IDLE);

    case (phase_cur)
      PH_IDLE: begin
      end
      PH_LOW: begin
        result.drive_low = 1'b1;
        tick_count_next  = count_inc;
        if (count_inc >= reset_low_ticks) begin
          phase_next      = PH_RELEASE;
          tick_count_next = '0;
        end
      end
      PH_RELEASE: begin
        tick_count_next = count_inc;
        if (count_inc >= release_limit) begin
          phase_next      = PH_RESP_LOW;
          tick_count_next = '0;
        end
      end
      PH_RESP_LOW: begin
        if (!tick_in.line_level) begin
          phase_next      = PH_RESP_HIGH;
          tick_count_next = '0;
        end else begin
          tick_count_next = count_inc;
          if (count_inc >= timeout_limit) begin
            result.no_response = 1'b1;
            phase_next         = PH_IDLE;
            tick_count_next    = '0;
          end
        end
      end
      PH_RESP_HIGH: begin
        if (tick_in.line_level) begin
          phase_next      = PH_BIT_LOW;
          tick_count_next = '0;
          bit_index_next  = '0;
          byte_index_next = '0;
          shift_byte_next = '0;
        end else begin
          tick_count_next = count_inc;
          if (count_inc >= timeout_limit) begin
            result.no_response = 1'b1;
            phase_next         = PH_IDLE;
            tick_count_next    = '0;
          end
        end
      end
      PH_BIT_LOW: begin
        tick_count_next = count_inc;
        if (!tick_in.line_level || (count_inc >= timeout_limit)) begin
          phase_next      = PH_BIT_HIGH;
          tick_count_next = '0;
        end
      end
      PH_BIT_HIGH: begin
        tick_count_next = count_inc;
        if (tick_in.line_level || (count_inc >= timeout_limit)) begin
          phase_next      = PH_DELAY;
          tick_count_next = '0;
        end
      end
      PH_DELAY: begin
        if (count_cur < delay_limit) begin
          tick_count_next = count_inc;
        end else begin
          tick_count_next = '0;
          phase_next      = PH_BIT_LOW;
          if (bit_cur == BIT_IDX_W'(BITS_PER_BYTE - 1)) begin
            // Byte complete: present it and start the next one.
            result.byte_valid = 1'b1;
            result.byte_value = sampled_byte;
            bit_index_next    = '0;
            shift_byte_next   = '0;
            if (bytes_done >= want_bytes) begin
              result.last_byte = 1'b1;
              byte_index_next  = '0;
              phase_next       = PH_IDLE;
            end else begin
              byte_index_next = byte_cur + BYTE_IDX_W'(1);
            end
          end else begin
            shift_byte_next = sampled_byte;
            bit_index_next  = bit_cur + BIT_IDX_W'(1);
          end
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      tick_count <= '0;
      bit_index  <= '0;
      byte_index <= '0;
      shift_byte <= '0;
    end else if (tick_accept) begin
      phase      <= phase_next;
      tick_count <= tick_count_next;
      bit_index  <= bit_index_next;
      byte_index <= byte_index_next;
      shift_byte <= shift_byte_next;
    end
  end

  // Configuration registers; unused indexes fall through the default arm.
  always_ff @(posedge clk) begin
    if (rst) begin
      reset_low_ticks    <= RESET_LOW_TICKS_RST;
      release_ticks      <= RELEASE_TICKS_RST;
      timeout_ticks      <= TIMEOUT_TICKS_RST;
      sample_delay_ticks <= SAMPLE_DELAY_TICKS_RST;
      bytes_to_read      <= BYTES_TO_READ_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_RESET_LOW_TICKS:    reset_low_ticks    <= cfg_data;
        CFG_RELEASE_TICKS:      release_ticks      <= cfg_data[7:0];
        CFG_TIMEOUT_TICKS:      timeout_ticks      <= cfg_data[7:0];
        CFG_SAMPLE_DELAY_TICKS: sample_delay_ticks <= cfg_data[7:0];
        CFG_BYTES_TO_READ:      bytes_to_read      <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  // Result register with a spare entry, so a stalled consumer does not stop
  // the next request from being taken.
  swsr_skid u_skid (
    .clk        (clk),
    .rst        (rst),
    .push_valid (tick_in.valid),
    .push_ready (skid_ready),
    .push_data  (result),
    .pop_valid  (result_out.valid),
    .pop_ready  (result_out.ready),
    .pop_data   (out_data)
  );

  assign result_out.drive_low   = out_data.drive_low;
  assign result_out.byte_valid  = out_data.byte_valid;
  assign result_out.byte_value  = out_data.byte_value;
  assign result_out.last_byte   = out_data.last_byte;
  assign result_out.no_response = out_data.no_response;
  assign result_out.busy_res    = out_data.busy_res;

endmodule

`default_nettype wire
